// ===== rtl/core/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and constants for the bitmap page allocator
// Request codes, status codes and the controller/datapath command struct.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int unsigned MAX_FRAGMENTS_DEF = 4096;
    localparam int unsigned WORD_BITS_DEF     = 32;
    localparam int unsigned CFG_W             = 13;
    localparam int unsigned IDX_W             = 12;
    localparam int unsigned LEN_W             = 13;
    localparam int unsigned CNT_W             = 13;
    localparam logic [CFG_W-1:0] TOTAL_RESET  = 13'd4096;
    localparam logic [CNT_W-1:0] COUNT_MAX    = 13'h1FFF;

    localparam logic [2:0] FUNC_ALLOC_ONE = 3'd0;
    localparam logic [2:0] FUNC_ALLOC_RUN = 3'd1;
    localparam logic [2:0] FUNC_FREE_ONE  = 3'd2;
    localparam logic [2:0] FUNC_FREE_RUN  = 3'd3;
    localparam logic [2:0] FUNC_MARK_USED = 3'd4;
    localparam logic [2:0] FUNC_MARK_FREE = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BADARG  = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic clear;     // clearing pass: fill one word with ones
        logic load;      // latch request
        logic scan_rd;   // read word at scan pointer
        logic scan_step; // consume read word (search)
        logic wr_rd;     // read word at write pointer
        logic wr_step;   // apply write to read word
        logic done;      // present result
    } bpa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_alloc;
        logic bad;       // bad argument or range
        logic nospace;   // count too low or run longer than search limit
        logic found;     // run found, write pointer at its start
        logic scan_end;  // search pointer reached limit
        logic wr_end;    // no pages left to write
        logic zero_len;  // free/mark with nothing to do
        logic clear_end; // last word of the clearing pass
    } bpa_sts_t;

endpackage

// ===== rtl/core/bpa_datapath.sv =====
// ----------------------------------------------------------------------------
// bpa_datapath: bitmap memory, page-serial run search and page writer
// The search walks one page per read, skipping full words in one read.
// ----------------------------------------------------------------------------
module bpa_datapath
    import bpa_pkg::*;
#(
    parameter int unsigned MAX_FRAGMENTS = MAX_FRAGMENTS_DEF,
    parameter int unsigned WORD_BITS     = WORD_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [2:0]       func,
    input  logic [IDX_W-1:0] fragment_index,
    input  logic [LEN_W-1:0] run_length,
    input  logic [CFG_W-1:0] total_reg,
    input  bpa_cmd_t         cmd,
    output bpa_sts_t         sts,
    output logic [1:0]       status,
    output logic [IDX_W-1:0] found_index,
    output logic [CNT_W-1:0] free_count
);
    localparam int unsigned NWORDS = (MAX_FRAGMENTS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned NBITS  = NWORDS * WORD_BITS;
    localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int unsigned BW     = $clog2(WORD_BITS);
    localparam int unsigned PW     = $clog2(NBITS + 1) + 1; // page pointer
    localparam int unsigned LW     = PW + LEN_W;

    // Bitmap memory, set bit = page used. Filled with ones by the clearing
    // pass that runs right after reset (one word per cycle).
    logic [WORD_BITS-1:0] mem [NWORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [AW-1:0]        clr_reg;

    logic [LEN_W-1:0] len_reg;
    logic [PW-1:0]    p_reg;      // search page / write page
    logic [LEN_W-1:0] run_reg;    // free pages in the current search run
    logic [LEN_W-1:0] left_reg;   // pages left to write
    logic [PW-1:0]    limit_reg;
    logic [PW-1:0]    start_reg;
    logic             found_reg;
    logic             alloc_reg;
    logic             setbit_reg;
    logic             bad_reg;
    logic             nospace_reg;
    logic             zero_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [1:0]       status_reg;
    logic [IDX_W-1:0] found_idx_reg;

    logic [CFG_W-1:0]     eff_total;
    logic [CFG_W-1:0]     limit_now;
    logic                 is_alloc_now;
    logic [LEN_W-1:0]     len_eff;
    logic [LW-1:0]        span;
    logic [AW-1:0]        p_word;
    logic [BW-1:0]        p_bit;
    logic                 bit_used;
    logic                 skip;
    logic                 hit;
    logic [LEN_W-1:0]     run_next;
    logic [PW-1:0]        start_next;
    logic [WORD_BITS-1:0] onehot;
    logic [WORD_BITS-1:0] write_word;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    assign eff_total    = (32'(total_reg) < MAX_FRAGMENTS) ? total_reg : CFG_W'(MAX_FRAGMENTS);
    // whole words only; WORD_BITS is a power of two
    assign limit_now    = eff_total & ~CFG_W'(WORD_BITS - 1);
    assign is_alloc_now = (func == FUNC_ALLOC_ONE) || (func == FUNC_ALLOC_RUN);
    assign len_eff      = (func == FUNC_ALLOC_ONE || func == FUNC_FREE_ONE) ? LEN_W'(1) : run_length;
    assign span         = LW'(fragment_index) + LW'(len_eff);
    assign p_word       = p_reg[BW +: AW];
    assign p_bit        = p_reg[BW-1:0];
    assign bit_used     = rd_data_reg[p_bit];

    // word-skip at a word boundary with empty run
    assign skip       = (p_bit == '0) && (run_reg == '0) && (rd_data_reg == '1);
    assign run_next   = bit_used ? '0 : run_reg + LEN_W'(1);
    assign hit        = !skip && !bit_used && (run_next == len_reg);
    assign start_next = p_reg + PW'(1) - PW'(len_reg);

    assign onehot     = WORD_BITS'(1) << p_bit;
    assign write_word = setbit_reg ? (rd_data_reg | onehot) : (rd_data_reg & ~onehot);

    assign mem_we    = cmd.clear || cmd.wr_step;
    assign mem_waddr = cmd.clear ? clr_reg : p_word;
    assign mem_wdata = cmd.clear ? '1 : write_word;

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.scan_rd || cmd.wr_rd) begin
            rd_data_reg <= mem[p_word];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clr_reg       <= '0;
            len_reg       <= '0;
            p_reg         <= '0;
            run_reg       <= '0;
            left_reg      <= '0;
            limit_reg     <= '0;
            start_reg     <= '0;
            found_reg     <= 1'b0;
            alloc_reg     <= 1'b0;
            setbit_reg    <= 1'b0;
            bad_reg       <= 1'b0;
            nospace_reg   <= 1'b0;
            zero_reg      <= 1'b0;
            cnt_reg       <= '0;
            status_reg    <= ST_OK;
            found_idx_reg <= '0;
        end else begin
            if (cmd.clear) begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.load) begin
                len_reg    <= len_eff;
                limit_reg  <= PW'(limit_now);
                run_reg    <= '0;
                found_reg  <= 1'b0;
                alloc_reg  <= is_alloc_now;
                setbit_reg <= is_alloc_now || (func == FUNC_MARK_USED);
                if (is_alloc_now) begin
                    p_reg       <= '0;
                    left_reg    <= '0;
                    bad_reg     <= (len_eff == '0);
                    nospace_reg <= (cnt_reg < len_eff) || (PW'(len_eff) > PW'(limit_now));
                    zero_reg    <= 1'b0;
                end else begin
                    p_reg       <= PW'(fragment_index);
                    left_reg    <= len_eff;
                    bad_reg     <= (func > FUNC_MARK_FREE) || (span > LW'(eff_total));
                    nospace_reg <= 1'b0;
                    zero_reg    <= (len_eff == '0);
                end
            end
            if (cmd.scan_step) begin
                if (skip) begin
                    p_reg <= p_reg + PW'(WORD_BITS);
                end else if (hit) begin
                    // run complete: point the writer at its first page
                    run_reg   <= run_next;
                    found_reg <= 1'b1;
                    start_reg <= start_next;
                    p_reg     <= start_next;
                    left_reg  <= len_reg;
                end else begin
                    run_reg <= run_next;
                    p_reg   <= p_reg + PW'(1);
                end
            end
            if (cmd.wr_step) begin
                // count adjusts only when the bit changes
                if (setbit_reg && !bit_used && cnt_reg != '0) begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end else if (!setbit_reg && bit_used && cnt_reg != COUNT_MAX) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                p_reg    <= p_reg + PW'(1);
                left_reg <= left_reg - LEN_W'(1);
            end
            if (cmd.done) begin
                if (bad_reg) begin
                    status_reg <= ST_BADARG;
                end else if (alloc_reg && !found_reg) begin
                    status_reg <= ST_NOSPACE;
                end else begin
                    status_reg <= ST_OK;
                end
                found_idx_reg <= (alloc_reg && found_reg) ? start_reg[IDX_W-1:0] : '0;
            end
        end
    end

    assign sts.is_alloc  = alloc_reg;
    assign sts.bad       = bad_reg;
    assign sts.nospace   = nospace_reg;
    assign sts.found     = found_reg;
    assign sts.scan_end  = (p_reg >= limit_reg);
    assign sts.wr_end    = (left_reg == '0);
    assign sts.zero_len  = zero_reg;
    assign sts.clear_end = (clr_reg == AW'(NWORDS - 1));

    assign status      = status_reg;
    assign found_index = found_idx_reg;
    assign free_count  = cnt_reg;

endmodule

// ===== rtl/core/bpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpa_ctrl: request sequencer
// Clear, load, check, search (read/step per page), write (read/step per page), respond.
// ----------------------------------------------------------------------------
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  bpa_sts_t sts,
    output bpa_cmd_t cmd,
    output logic     busy,
    output logic     done
);
    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_CHECK, S_SRD, S_SSTEP, S_WRD, S_WSTEP, S_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT:  begin
                cmd.clear = 1'b1;
                if (sts.clear_end) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:  begin
                if (start) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.bad || sts.nospace || sts.zero_len) begin
                    state_next = S_RESP;
                end else if (sts.is_alloc) begin
                    state_next = S_SRD;
                end else begin
                    state_next = S_WRD;
                end
            end
            S_SRD:   begin
                if (sts.found) begin
                    state_next = S_WRD;
                end else if (sts.scan_end) begin
                    state_next = S_RESP;
                end else begin
                    cmd.scan_rd = 1'b1;
                    state_next  = S_SSTEP;
                end
            end
            S_SSTEP: begin
                cmd.scan_step = 1'b1;
                state_next    = S_SRD;
            end
            S_WRD:   begin
                if (sts.wr_end) begin
                    state_next = S_RESP;
                end else begin
                    cmd.wr_rd  = 1'b1;
                    state_next = S_WSTEP;
                end
            end
            S_WSTEP: begin
                cmd.wr_step = 1'b1;
                state_next  = S_WRD;
            end
            S_RESP:  begin
                cmd.done   = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_INIT;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= cmd.done;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("done held two cycles");
    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE) else $error("done outside idle");
    a_resp_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RESP |=> done_reg) else $error("response lost");

endmodule

// ===== rtl/core/bitmap_page_allocator_top.sv =====
// ----------------------------------------------------------------------------
// bitmap_page_allocator_top: first-fit bitmap page allocator
//
// Channel   | Signals                                   | Transfer when
// ----------+-------------------------------------------+-------------------
// request   | start, busy, func, fragment_index,        | start && !busy
//           | run_length                                |
// result    | done, status, found_index, free_count     | done (one cycle)
// config    | total_fragments_we, total_fragments_wdata | total_fragments_we
//
// Sequence: after the request transfer, a check state, then a read and a
//   step per page walked by the search (a fully used word at a word
//   boundary is skipped in one read and step), one more read state to see
//   the hit or the limit, a read and a step per page written plus one more
//   read state, and a response state, from which done is registered. The
//   single-ported bitmap memory and the one-page-per-step search set this.
// Reset: asynchronous, all pages used, count zero, total 4096. A clearing
//   pass fills the bitmap with ones, one word per cycle; busy is high
//   meanwhile.
// The result receiver cannot stall; busy holds off new requests.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_top
    import bpa_pkg::*;
#(
    parameter int unsigned MAX_FRAGMENTS = MAX_FRAGMENTS_DEF,
    parameter int unsigned WORD_BITS     = WORD_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [2:0]       func,
    input  logic [IDX_W-1:0] fragment_index,
    input  logic [LEN_W-1:0] run_length,
    output logic             done,
    output logic [1:0]       status,
    output logic [IDX_W-1:0] found_index,
    output logic [CNT_W-1:0] free_count,
    input  logic             total_fragments_we,
    input  logic [CFG_W-1:0] total_fragments_wdata
);
    logic [CFG_W-1:0] total_reg;
    bpa_cmd_t         cmd;
    bpa_sts_t         sts;

    // Configuration register; the user must write it only while idle, the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            total_reg <= TOTAL_RESET;
        end else if (total_fragments_we) begin
            total_reg <= total_fragments_wdata;
        end
    end

    bpa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .sts        (sts),
        .cmd        (cmd),
        .busy       (busy),
        .done       (done)
    );

    bpa_datapath #(
        .MAX_FRAGMENTS (MAX_FRAGMENTS),
        .WORD_BITS     (WORD_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .func           (func),
        .fragment_index (fragment_index),
        .run_length     (run_length),
        .total_reg      (total_reg),
        .cmd            (cmd),
        .sts            (sts),
        .status         (status),
        .found_index    (found_index),
        .free_count     (free_count)
    );

endmodule
